### rtl/cdd_pkg.sv
// Shared types and constants for the code block dedent checker.
`default_nettype none

package cdd_pkg;

   localparam int unsigned CHAR_W     = 21;
   localparam int unsigned CHAR_BITS  = 21;
   localparam int unsigned LINE_W     = 16;
   localparam int unsigned ERR_COL_W  = 7;
   localparam int unsigned MAX_INDENT_DEF = 64;

   // Bits of a code point that take part in the comparisons
   localparam logic [CHAR_W-1:0] CHAR_MASK =
      (CHAR_BITS >= CHAR_W) ? {CHAR_W{1'b1}} : CHAR_W'((64'd1 << CHAR_BITS) - 64'd1);

   localparam logic [CHAR_W-1:0] CH_NL  = CHAR_W'(10);
   localparam logic [CHAR_W-1:0] CH_SP  = CHAR_W'(32);
   localparam logic [CHAR_W-1:0] CH_TAB = CHAR_W'(9);

   localparam logic [LINE_W-1:0] LINE_FIRST = LINE_W'(1);
   localparam logic [LINE_W-1:0] LINE_MAX   = {LINE_W{1'b1}};

   typedef enum logic [2:0] {
      PH_FIRST_LEAD,
      PH_FIRST_TEXT,
      PH_SECOND,
      PH_INDENT,
      PH_TEXT,
      PH_DROP
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_MIXED,
      ST_SHALLOW,
      ST_DEEP
   } status_type;

   typedef struct packed {
      logic [CHAR_W-1:0]    out_char;
      logic                 char_valid;
      status_type           status;
      logic [LINE_W-1:0]    err_line;
      logic [ERR_COL_W-1:0] err_col;
      logic                 block_end;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/code_block_dedent_checker_core.sv
// Top level of the code block dedent checker: handshakes and result register.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  req_ch, req_end_of_code
//   rsp_      out        rsp_valid/rsp_stall  rsp_out_char, rsp_char_valid,
//                                             rsp_status, rsp_err_line,
//                                             rsp_err_col, rsp_block_end
//
// One character per clock while req_stall is low. Each accepted character is
// checked against the registered indent state and at most one result lands in
// the result register on the same edge, from which it is presented.
// The input is stalled only while a result sits in the register and rsp_stall
// is high; a result taken in a cycle frees the register for the next one.
// Reset is synchronous and returns to the start of a block; the indent store
// needs no clearing pass since each entry is written before it is read.
`default_nettype none

module code_block_dedent_checker_core #(
   parameter int unsigned MAX_INDENT = cdd_pkg::MAX_INDENT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [cdd_pkg::CHAR_W-1:0]    req_ch,
   input  logic                          req_end_of_code,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [cdd_pkg::CHAR_W-1:0]    rsp_out_char,
   output logic                          rsp_char_valid,
   output logic [1:0]                    rsp_status,
   output logic [cdd_pkg::LINE_W-1:0]    rsp_err_line,
   output logic [cdd_pkg::ERR_COL_W-1:0] rsp_err_col,
   output logic                          rsp_block_end
);
   import cdd_pkg::*;

   logic    take;
   logic    emit;
   rsp_type step_rsp;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // Hold the input only while an undelivered result blocks the register
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign take      = req_valid && !req_stall;

   cdd_ctrl #(
      .MAX_INDENT (MAX_INDENT)
   ) u_ctrl (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .ch    (req_ch),
      .last  (req_end_of_code),
      .emit  (emit),
      .rsp   (step_rsp)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (take && emit) begin
         // load a fresh result; the register is free or being drained now
         rsp_valid_in = 1'b1;
         rsp_data_in  = step_rsp;
      end else if (!rsp_stall) begin
         // drop the delivered transfer
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_char   = rsp_data_ff.out_char;
   assign rsp_char_valid = rsp_data_ff.char_valid;
   assign rsp_status     = rsp_data_ff.status;
   assign rsp_err_line   = rsp_data_ff.err_line;
   assign rsp_err_col    = rsp_data_ff.err_col;
   assign rsp_block_end  = rsp_data_ff.block_end;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !take)
      else $error("character accepted while a result is held");

   a_error_ends_block: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status != ST_OK |->
         rsp_data_ff.block_end && !rsp_data_ff.char_valid)
      else $error("error result without block end or with a kept character");

endmodule

`default_nettype wire

### rtl/cdd_ctrl.sv
// Per-character indent tracking, indent store and result formation.
`default_nettype none

module cdd_ctrl #(
   parameter int unsigned MAX_INDENT = cdd_pkg::MAX_INDENT_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       take,
   input  logic [cdd_pkg::CHAR_W-1:0] ch,
   input  logic                       last,
   output logic                       emit,
   output cdd_pkg::rsp_type           rsp
);
   import cdd_pkg::*;

   localparam int unsigned CW = $clog2(MAX_INDENT + 1);
   localparam int unsigned AW = $clog2(MAX_INDENT);
   localparam logic [CW-1:0] COL_LIMIT = CW'(MAX_INDENT);

   phase_type           phase_ff, phase_in;
   logic [CW-1:0]       ref_len_ff, ref_len_in;
   logic [CW-1:0]       common_len_ff, common_len_in;
   logic [CW-1:0]       col_ff, col_in;
   logic                local_ff, local_in;
   logic [LINE_W-1:0]   line_ff, line_in;

   // Reference indent, 1 = tab; entries below ref_len are always written first
   logic                ref_mem [MAX_INDENT];
   logic                rd_bit_ff;
   logic [AW-1:0]       rd_addr;
   logic [AW-1:0]       wr_addr;
   logic                wr_en;

   logic [CHAR_W-1:0]   c;
   logic                is_nl, is_tab, is_blank, match;
   logic                keep;
   status_type          err;
   logic [CW-1:0]       col_inc;
   logic [LINE_W-1:0]   line_inc;
   logic [31:0]         col_wide;

   always_comb begin
      c        = ch & CHAR_MASK;
      is_nl    = (c == CH_NL);
      is_tab   = (c == CH_TAB);
      is_blank = (c == CH_SP) || is_tab;
      match    = is_blank && (rd_bit_ff == is_tab);
      col_inc  = col_ff + CW'(1);
      line_inc = (line_ff == LINE_MAX) ? line_ff : line_ff + LINE_W'(1);
      wr_addr  = col_ff[AW-1:0];

      phase_in      = phase_ff;
      ref_len_in    = ref_len_ff;
      common_len_in = common_len_ff;
      col_in        = col_ff;
      local_in      = local_ff;
      line_in       = line_ff;
      wr_en         = 1'b0;
      emit          = 1'b0;
      keep          = 1'b0;
      err           = ST_OK;

      if (take) begin
         unique case (phase_ff)
            PH_FIRST_LEAD, PH_FIRST_TEXT: begin
               if (is_nl) begin
                  line_in  = line_inc;
                  col_in   = '0;
                  phase_in = PH_SECOND;
                  emit     = 1'b1;
                  keep     = 1'b1;
               end else if (!(phase_ff == PH_FIRST_LEAD && is_blank)) begin
                  phase_in = PH_FIRST_TEXT;
                  emit     = 1'b1;
                  keep     = 1'b1;
               end
            end
            PH_SECOND: begin
               if (is_blank) begin
                  if (col_ff >= COL_LIMIT) begin
                     emit = 1'b1;
                     err  = ST_DEEP;
                  end else begin
                     wr_en  = 1'b1;
                     col_in = col_inc;
                  end
               end else begin
                  common_len_in = col_ff;
                  ref_len_in    = col_ff;
                  emit          = 1'b1;
                  keep          = 1'b1;
                  if (is_nl) begin
                     line_in  = line_inc;
                     col_in   = '0;
                     local_in = 1'b1;
                     phase_in = PH_INDENT;
                  end else begin
                     phase_in = PH_TEXT;
                  end
               end
            end
            PH_INDENT: begin
               if (is_nl) begin
                  line_in  = line_inc;
                  col_in   = '0;
                  local_in = 1'b1;
                  emit     = 1'b1;
                  keep     = 1'b1;
               end else if (col_ff < common_len_ff) begin
                  // inside the common indent: drop it, but it must match
                  if (match) begin
                     col_in = col_inc;
                  end else begin
                     emit = 1'b1;
                     err  = is_blank ? ST_MIXED : ST_SHALLOW;
                  end
               end else if (local_ff && col_ff < ref_len_ff) begin
                  emit = 1'b1;
                  if (match) begin
                     col_in = col_inc;
                     keep   = 1'b1;
                  end else if (is_blank) begin
                     err = ST_MIXED;
                  end else begin
                     ref_len_in = col_ff;
                     phase_in   = PH_TEXT;
                     keep       = 1'b1;
                  end
               end else begin
                  // deeper than the reference: record the new indent in place
                  local_in = 1'b0;
                  emit     = 1'b1;
                  if (is_blank) begin
                     if (col_ff >= COL_LIMIT) begin
                        err = ST_DEEP;
                     end else begin
                        wr_en  = 1'b1;
                        col_in = col_inc;
                        keep   = 1'b1;
                     end
                  end else begin
                     ref_len_in = col_ff;
                     phase_in   = PH_TEXT;
                     keep       = 1'b1;
                  end
               end
            end
            PH_TEXT: begin
               if (is_nl) begin
                  line_in  = line_inc;
                  col_in   = '0;
                  local_in = 1'b1;
                  phase_in = PH_INDENT;
               end
               emit = 1'b1;
               keep = 1'b1;
            end
            PH_DROP: begin
            end
            default: begin
               phase_in = PH_DROP;
            end
         endcase

         if (err != ST_OK) begin
            phase_in = PH_DROP;
         end

         // block end: always report unless already dropping, then restart
         if (last) begin
            if (phase_ff != PH_DROP) begin
               emit = 1'b1;
            end
            phase_in      = PH_FIRST_LEAD;
            ref_len_in    = '0;
            common_len_in = '0;
            col_in        = '0;
            local_in      = 1'b1;
            line_in       = LINE_FIRST;
         end
      end

      rd_addr  = (col_in < COL_LIMIT) ? col_in[AW-1:0] : '0;
      col_wide = 32'(col_ff);

      rsp.out_char   = keep ? c : '0;
      rsp.char_valid = keep;
      rsp.status     = err;
      rsp.err_line   = (err != ST_OK) ? line_ff : '0;
      rsp.err_col    = (err != ST_OK) ? col_wide[ERR_COL_W-1:0] : '0;
      rsp.block_end  = (err != ST_OK) || last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_FIRST_LEAD;
         ref_len_ff    <= '0;
         common_len_ff <= '0;
         col_ff        <= '0;
         local_ff      <= 1'b1;
         line_ff       <= LINE_FIRST;
      end else begin
         phase_ff      <= phase_in;
         ref_len_ff    <= ref_len_in;
         common_len_ff <= common_len_in;
         col_ff        <= col_in;
         local_ff      <= local_in;
         line_ff       <= line_in;
      end
   end

   // Read ahead at the next column so the bit lines up with col_ff
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ref_mem[wr_addr] <= is_tab;
      end
      rd_bit_ff <= ref_mem[rd_addr];
   end

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      col_ff <= COL_LIMIT)
      else $error("column beyond indent limit");

   a_ref_covers_common: assert property (@(posedge clock) disable iff (reset)
      ref_len_ff >= common_len_ff)
      else $error("reference indent shorter than common indent");

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      take && last |=> phase_ff == PH_FIRST_LEAD && col_ff == '0 && line_ff == LINE_FIRST)
      else $error("block state not restarted after final character");

endmodule

`default_nettype wire
